// File: rtl/high_tower_trigger_emulator_core_defines.svh
// Assertion macros shared by the high tower trigger emulator RTL.
`ifndef HIGH_TOWER_TRIGGER_EMULATOR_CORE_DEFINES_SVH
`define HIGH_TOWER_TRIGGER_EMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HTTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("htte assertion failed");

// Next-cycle implication, checked outside reset.
`define HTTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("htte assertion failed");

`endif

// File: rtl/htte_pkg.sv
// Shared types and constants of the high tower trigger emulator.
`default_nettype none
package htte_pkg;

    // Field widths.
    localparam int IdW   = 13;
    localparam int AdcW  = 12;
    localparam int PedW  = 12;
    localparam int TrigW = 6;

    // Highest valid tower identifier.
    localparam logic [IdW-1:0] MAX_TOWER_ID = 13'd4800;

    // Stream data widths, padded to whole bytes.
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;

    // Event queue depth between front and back (power of two).
    localparam int QDepth = 2;
    localparam int QAw    = $clog2(QDepth);

    // Configuration register indexes and reset values.
    typedef enum logic {
        REG_PED_TARGET = 1'b0,
        REG_TRIG_THR   = 1'b1
    } t_reg_idx;

    localparam logic [PedW-1:0]  PED_TARGET_RST = 12'd8;
    localparam logic [TrigW-1:0] TRIG_THR_RST   = 6'd10;

    // Summary of one finished event, handed from front to back.
    typedef struct packed {
        logic [AdcW-1:0] max_adc;
        logic [IdW-1:0]  max_id;
        logic [PedW-1:0] max_ped;
    } t_evt;

endpackage
`default_nettype wire

// File: rtl/htte_front.sv
// Front end: accepts tower hits and tracks the highest good tower of the event.
`default_nettype none
module htte_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [htte_pkg::IdW-1:0]  i_tower_id,
    input  wire logic [htte_pkg::AdcW-1:0] i_adc_value,
    input  wire logic                    i_tower_good,
    input  wire logic [htte_pkg::PedW-1:0] i_tower_pedestal,
    input  wire logic                    i_last_hit,
    input  wire logic                    i_q_full,
    output logic                         o_push,
    output htte_pkg::t_evt               o_evt
);
    import htte_pkg::*;

    t_evt r_best;
    t_evt n_best;
    logic w_accept;
    logic w_take;

    // A hit is taken whenever the queue has room for a possible event summary.
    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // Keep the hit if it is good, in range and strictly above the best so far.
    assign w_take = i_tower_good && (i_tower_id != '0) && (i_tower_id <= MAX_TOWER_ID)
                    && (i_adc_value > r_best.max_adc);

    always_comb begin
        n_best = r_best;
        if (w_take) begin
            n_best.max_adc = i_adc_value;
            n_best.max_id  = i_tower_id;
            n_best.max_ped = i_tower_pedestal;
        end
    end

    // The last hit closes the event: its summary goes to the queue.
    assign o_push = w_accept && i_last_hit;
    assign o_evt  = n_best;

    // Running maximum, cleared at reset and after each event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (w_accept) begin
            if (i_last_hit) begin
                r_best <= '0;
            end else begin
                r_best <= n_best;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/htte_queue.sv
// Short event queue between the front and back ends.
`default_nettype none
`include "high_tower_trigger_emulator_core_defines.svh"
module htte_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  htte_pkg::t_evt      i_evt,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output htte_pkg::t_evt      o_evt
);
    import htte_pkg::*;

    t_evt           r_mem [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QAw:0]   r_count;

    assign o_full  = (r_count == (QAw+1)'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `HTTE_ASSERT_NOW(a_q_no_overflow, i_push, !o_full || i_pop)
    `HTTE_ASSERT_NOW(a_q_no_underflow, i_pop, o_valid)
    `HTTE_ASSERT_NOW(a_q_count_bound, 1'b1, r_count <= (QAw+1)'(QDepth))

endmodule
`default_nettype wire

// File: rtl/htte_back.sv
// Back end: pedestal correction, trigger decision and the result register.
`default_nettype none
`include "high_tower_trigger_emulator_core_defines.svh"
module htte_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  htte_pkg::t_evt                  i_evt,
    output logic                            o_pop,
    input  wire logic [htte_pkg::PedW-1:0]  i_ped_target,
    input  wire logic [htte_pkg::TrigW-1:0] i_trig_thr,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [htte_pkg::OutDataW-1:0]   o_data,
    output logic                            o_found
);
    import htte_pkg::*;

    logic                r_valid;
    logic [OutDataW-1:0] r_data;
    logic                r_found;

    logic                w_found;
    logic [PedW:0]       w_diff;
    logic                w_sub;
    logic [PedW:0]       w_neg;
    logic [PedW-1:0]     w_mag;
    logic [PedW-2:0]     w_shift;
    logic [3:0]          w_shift_f;
    logic [AdcW-1:0]     w_adc10;
    logic [AdcW-1:0]     w_corr10;
    logic [TrigW-1:0]    w_raw;
    logic [TrigW-1:0]    w_corr;
    logic                w_trig;
    logic [OutDataW-1:0] n_data;

    // Take the next event when the result register is empty or being drained.
    assign o_pop = i_q_valid && (!r_valid || i_ready);

    // Pedestal shift: rounded 12-bit to 10-bit step, folded into 11..14 when large.
    always_comb begin
        w_found  = (i_evt.max_adc != '0);
        w_diff   = {1'b0, i_evt.max_ped} - {1'b0, i_ped_target};
        w_sub    = !w_diff[PedW];
        w_neg    = '0 - w_diff;
        w_mag    = w_sub ? w_diff[PedW-1:0] : w_neg[PedW-1:0];
        w_shift  = {1'b0, w_mag[PedW-1:2]} + {{(PedW-2){1'b0}}, (w_mag[1:0] == 2'b11)};
        if (w_shift > (PedW-1)'(15)) begin
            w_shift_f = 4'd11 + {2'b00, w_shift[1:0] + 2'b01};
        end else begin
            w_shift_f = w_shift[3:0];
        end
        w_adc10  = {2'b00, i_evt.max_adc[AdcW-1:2]};
        w_corr10 = w_sub ? (w_adc10 - {8'd0, w_shift_f}) : (w_adc10 + {8'd0, w_shift_f});
        // Six-bit compression: divide by eight, bit six folded into bit five.
        w_raw    = {i_evt.max_adc[11] | i_evt.max_adc[10], i_evt.max_adc[9:5]};
        w_corr   = {w_corr10[9] | w_corr10[8], w_corr10[7:3]};
        w_trig   = w_corr > i_trig_thr;
        n_data   = '0;
        if (w_found) begin
            n_data[12:0]  = i_evt.max_id;
            n_data[24:13] = i_evt.max_adc;
            n_data[30:25] = w_raw;
            n_data[36:31] = w_corr;
            n_data[37]    = w_trig;
        end
    end

    // Result register with its own valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data  <= n_data;
            r_found <= w_found;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_found = r_found;

    `HTTE_ASSERT_NOW(a_trig_needs_found, r_valid && r_data[37], r_found)
    `HTTE_ASSERT_NOW(a_empty_event_zero, r_valid && !r_found, r_data == '0)
    `HTTE_ASSERT_NEXT(a_pop_loads_result, o_pop, r_valid)

endmodule
`default_nettype wire

// File: rtl/high_tower_trigger_emulator_core.sv
// Top level of the high tower trigger emulator: config registers and stream wiring.
//
//  Channel   Direction  Carries
//  s stream  in         one tower hit per transfer, tlast ends the event
//  m stream  out        one trigger result per event
//  APB       in/out     pedestal target (0x0), trigger threshold (0x4)
//
// A hit is taken every cycle while the event queue has room; one result per event
// is written into the queue with the last hit and then loaded from the queue into
// the output register once that register is free.
// The back end drains one event per cycle, so the queue stalls only when the
// output is held off. Reset (synchronous) clears the queue, running maximum and
// output valid and loads the register defaults; no clearing pass is needed.
`default_nettype none
module high_tower_trigger_emulator_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Hit stream; tdata: tower_id[12:0], adc_value[24:13], tower_pedestal[36:25].
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [htte_pkg::InDataW-1:0]   i_s_tdata,
    // tuser: tower_good[0].
    input  wire logic                           i_s_tuser,
    input  wire logic                           i_s_tlast,
    // Result stream; tdata: best_tower[12:0], best_adc[24:13], raw_trig_adc[30:25],
    // corrected_trig_adc[36:31], triggered[37].
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [htte_pkg::OutDataW-1:0]       o_m_tdata,
    // tuser: found[0].
    output logic                                o_m_tuser,
    // Configuration port.
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import htte_pkg::*;

    logic [PedW-1:0]  r_ped_target;
    logic [TrigW-1:0] r_trig_thr;
    t_reg_idx         w_idx;
    logic             w_cfg_wr;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_evt q_in;
    t_evt q_out;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_target <= PED_TARGET_RST;
            r_trig_thr   <= TRIG_THR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_PED_TARGET: r_ped_target <= pwdata[PedW-1:0];
                REG_TRIG_THR:   r_trig_thr   <= pwdata[TrigW-1:0];
                default:        r_trig_thr   <= r_trig_thr;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PED_TARGET: prdata = {{(32-PedW){1'b0}}, r_ped_target};
            REG_TRIG_THR:   prdata = {{(32-TrigW){1'b0}}, r_trig_thr};
            default:        prdata = '0;
        endcase
    end

    htte_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_tower_id       (i_s_tdata[12:0]),
        .i_adc_value      (i_s_tdata[24:13]),
        .i_tower_good     (i_s_tuser),
        .i_tower_pedestal (i_s_tdata[36:25]),
        .i_last_hit       (i_s_tlast),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_evt            (q_in)
    );

    htte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_evt   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_evt   (q_out)
    );

    htte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_evt        (q_out),
        .o_pop        (q_pop),
        .i_ped_target (r_ped_target),
        .i_trig_thr   (r_trig_thr),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_data       (o_m_tdata),
        .o_found      (o_m_tuser)
    );

endmodule
`default_nettype wire
